### hdl/lts_pkg.sv
// Shared types and constants for the L-system trigger sequencer.
`default_nettype none
package lts_pkg;

  // Sizes
  localparam int WORD_SLOTS = 16;
  localparam int RULE_SLOTS = 8;
  localparam int DUR_BITS   = 24;
  localparam int RULE_BITS  = 20;
  localparam int PULSE_BITS = 16;
  localparam int POS_W      = $clog2(WORD_SLOTS);
  localparam int LEN_W      = $clog2(WORD_SLOTS + 1);
  localparam int RLEN_W     = 4;
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

  localparam logic [DUR_BITS-1:0]   DUR_MAX     = '1;
  localparam logic [PULSE_BITS-1:0] PULSE_RESET = 16'd48;

  // Symbol codes
  localparam logic [1:0] SYM_A = 2'd0;
  localparam logic [1:0] SYM_B = 2'd1;
  localparam logic [1:0] SYM_C = 2'd2;
  localparam logic [1:0] SYM_D = 2'd3;

  // Register indexes on the config port
  localparam logic [2:0] REG_RULE_A = 3'd0;
  localparam logic [2:0] REG_RULE_B = 3'd1;
  localparam logic [2:0] REG_RULE_C = 3'd2;
  localparam logic [2:0] REG_RULE_D = 3'd3;
  localparam logic [2:0] REG_PULSE  = 3'd4;

  typedef struct packed {
    logic                restart;
    logic [DUR_BITS-1:0] dur_a_ticks;
    logic [DUR_BITS-1:0] dur_b_ticks;
    logic [DUR_BITS-1:0] dur_c_ticks;
    logic [DUR_BITS-1:0] dur_d_ticks;
  } tick_beat_t;

  typedef struct packed {
    logic             gate;
    logic [1:0]       symbol_now;
    logic [POS_W-1:0] position_now;
    logic [LEN_W-1:0] word_length;
    logic             symbol_start;
  } result_beat_t;

  typedef struct packed {
    logic [3:0][RULE_BITS-1:0] rules;
    logic [PULSE_BITS-1:0]     pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic rw_step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_rw;
    logic rw_done;
    logic out_full;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/lts_ctrl.sv
// Controller state machine: sequences tick, rewrite, commit and result emit.
`default_nettype none
module lts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick_valid,
  output logic                   tick_stall,
  input  wire logic              result_stall,
  input  wire lts_pkg::dp_stat_t stat,
  output lts_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_TICK    = 5'b00010,
    S_REWRITE = 5'b00100,
    S_COMMIT  = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a beat only when idle and the result register is free by this edge
  assign tick_stall = !((state == S_IDLE) && (!stat.out_full || !result_stall));
  assign accept     = tick_valid && !tick_stall;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) state_next = S_TICK;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = stat.need_rw ? S_REWRITE : S_EMIT;
      end
      S_REWRITE: begin
        if (stat.rw_done) begin
          state_next = S_COMMIT;
        end else begin
          cmd.rw_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hdl/lts_dp.sv
// Datapath: word store, rewrite buffer, tick/pulse counters, result register.
`default_nettype none
module lts_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lts_pkg::tick_beat_t  tick,
  input  wire logic                 result_stall,
  input  wire lts_pkg::cfg_t        cfg,
  input  wire lts_pkg::ctrl_cmd_t   cmd,
  output lts_pkg::dp_stat_t         stat,
  output logic                      result_valid,
  output lts_pkg::result_beat_t     result
);

  localparam int POS_W  = lts_pkg::POS_W;
  localparam int LEN_W  = lts_pkg::LEN_W;
  localparam int DUR_W  = lts_pkg::DUR_BITS;
  localparam int SLOTS  = lts_pkg::WORD_SLOTS;

  lts_pkg::tick_beat_t                in_q;
  logic [SLOTS-1:0][1:0]              word;
  logic [SLOTS-1:0][1:0]              rw;
  logic [SLOTS-1:0][1:0]              rw_next;
  logic [LEN_W-1:0]                   len;
  logic [POS_W-1:0]                   pos;
  logic [DUR_W-1:0]                   tc;
  logic [DUR_W-1:0]                   held;
  logic [lts_pkg::PULSE_BITS-1:0]     pl;
  logic                               started;
  logic [LEN_W-1:0]                   rd_idx;
  logic [LEN_W-1:0]                   wr_cnt;

  // Symbol duration from the latched beat
  function automatic logic [DUR_W-1:0] dur_of(lts_pkg::tick_beat_t b, logic [1:0] s);
    logic [DUR_W-1:0] d;
    begin
      unique case (s)
        lts_pkg::SYM_A: d = b.dur_a_ticks;
        lts_pkg::SYM_B: d = b.dur_b_ticks;
        lts_pkg::SYM_C: d = b.dur_c_ticks;
        lts_pkg::SYM_D: d = b.dur_d_ticks;
        default:        d = b.dur_a_ticks;
      endcase
      return d;
    end
  endfunction

  // ---- tick step ----
  logic [LEN_W-1:0] len0, len1, pos_inc;
  logic [POS_W-1:0] pos1, pos_new;
  logic [DUR_W-1:0] tc0, tc1, held1;
  logic             seed, fire, wrap;

  always_comb begin
    len0    = in_q.restart ? '0 : len;
    seed    = (len0 == '0);
    len1    = seed ? LEN_W'(1) : len0;
    pos1    = (in_q.restart || seed) ? '0 : pos;
    tc0     = in_q.restart ? '0 : tc;
    held1   = seed ? in_q.dur_a_ticks : held;
    tc1     = (tc0 == lts_pkg::DUR_MAX) ? tc0 : tc0 + DUR_W'(1);
    fire    = (tc1 >= held1);
    pos_inc = {1'b0, pos1} + LEN_W'(1);
    wrap    = (pos_inc >= len1);
    pos_new = wrap ? '0 : pos_inc[POS_W-1:0];
  end

  // ---- rewrite step: one word symbol expands into rw per cycle ----
  logic [1:0]                      cur_sym;
  logic [lts_pkg::RULE_BITS-1:0]   rule;
  logic [lts_pkg::RLEN_W-1:0]      rlen;
  logic [LEN_W-1:0]                room, take, offset;

  always_comb begin
    cur_sym = word[rd_idx[POS_W-1:0]];
    rule    = cfg.rules[cur_sym];
    rlen    = (rule[lts_pkg::RLEN_W-1:0] > lts_pkg::RLEN_W'(lts_pkg::RULE_SLOTS))
              ? lts_pkg::RLEN_W'(lts_pkg::RULE_SLOTS) : rule[lts_pkg::RLEN_W-1:0];
    room    = LEN_W'(SLOTS) - wr_cnt;
    take    = (LEN_W'(rlen) < room) ? LEN_W'(rlen) : room;
    rw_next = rw;
    offset  = '0;
    for (int j = 0; j < SLOTS; j++) begin
      offset = LEN_W'(j) - wr_cnt;
      if ((LEN_W'(j) >= wr_cnt) && (offset < take)) begin
        rw_next[j] = rule[lts_pkg::RLEN_W + 2 * offset[lts_pkg::CNT_W-2:0] +: 2];
      end
    end
  end

  assign stat.need_rw  = fire && wrap;
  assign stat.rw_done  = (rd_idx == len) || (wr_cnt == LEN_W'(SLOTS));
  assign stat.out_full = result_valid;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      pos <= '0;
      tc  <= '0;
      held <= '0;
      pl  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.tick) begin
        len <= len1;
        tc  <= fire ? '0 : tc1;
        pos <= fire ? pos_new : pos1;
        if (fire) pl <= cfg.pulse_ticks;
        // after a wrap the new duration comes with the commit
        if (fire && !wrap) begin
          held <= dur_of(in_q, word[pos_new]);
        end else begin
          held <= held1;
        end
      end
      if (cmd.commit) begin
        len  <= (wr_cnt == '0) ? LEN_W'(1) : wr_cnt;
        held <= dur_of(in_q, (wr_cnt == '0) ? lts_pkg::SYM_A : rw[0]);
      end
      if (cmd.emit) begin
        if (pl != '0) pl <= pl - lts_pkg::PULSE_BITS'(1);
      end
      // result register
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload and store registers
  always_ff @(posedge clk) begin
    if (cmd.load) in_q <= tick;
    if (cmd.tick) begin
      started <= seed || fire;
      rd_idx  <= '0;
      wr_cnt  <= '0;
      if (seed) word[0] <= lts_pkg::SYM_A;
    end
    if (cmd.rw_step) begin
      rw     <= rw_next;
      rd_idx <= rd_idx + LEN_W'(1);
      wr_cnt <= wr_cnt + take;
    end
    // empty rewrite reseeds with a
    if (cmd.commit) begin
      word <= (wr_cnt == '0) ? {rw[SLOTS-1:1], lts_pkg::SYM_A} : rw;
    end
    if (cmd.emit) begin
      result.gate         <= (pl != '0);
      result.symbol_now   <= word[pos];
      result.position_now <= pos;
      result.word_length  <= len;
      result.symbol_start <= started;
    end
  end

endmodule
`default_nettype wire

### hdl/lsystem_trigger_sequencer.sv
// Top level: config register file on the APB-style port, controller and datapath.
// An accepted tick beat is latched, then passes the tick state and, at the end of a
// word, the rewrite and commit states before the emit state loads the result register;
// the rewrite walks the word store one word symbol per cycle. A new tick beat is taken
// only when the controller is idle again and the result register is free.
// Reset (rst, synchronous): empty word, counters zero, rules empty, pulse length 48.
`default_nettype none
module lsystem_trigger_sequencer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  tick_valid,
  output logic                       tick_stall,
  input  wire lts_pkg::tick_beat_t   tick,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output lts_pkg::result_beat_t      result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  lts_pkg::cfg_t      cfg;
  lts_pkg::ctrl_cmd_t cmd;
  lts_pkg::dp_stat_t  stat;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rules       <= '0;
      cfg.pulse_ticks <= lts_pkg::PULSE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        lts_pkg::REG_RULE_A: cfg.rules[0] <= pwdata[lts_pkg::RULE_BITS-1:0];
        lts_pkg::REG_RULE_B: cfg.rules[1] <= pwdata[lts_pkg::RULE_BITS-1:0];
        lts_pkg::REG_RULE_C: cfg.rules[2] <= pwdata[lts_pkg::RULE_BITS-1:0];
        lts_pkg::REG_RULE_D: cfg.rules[3] <= pwdata[lts_pkg::RULE_BITS-1:0];
        lts_pkg::REG_PULSE:  cfg.pulse_ticks <= pwdata[lts_pkg::PULSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      lts_pkg::REG_RULE_A: prdata = 32'(cfg.rules[0]);
      lts_pkg::REG_RULE_B: prdata = 32'(cfg.rules[1]);
      lts_pkg::REG_RULE_C: prdata = 32'(cfg.rules[2]);
      lts_pkg::REG_RULE_D: prdata = 32'(cfg.rules[3]);
      lts_pkg::REG_PULSE:  prdata = 32'(cfg.pulse_ticks);
      default:             prdata = '0;
    endcase
  end

  lts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  lts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .result_stall (result_stall),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the L-system trigger sequencer: directed table, then random ticks.
module testbench;

  typedef struct {
    lts_pkg::tick_beat_t   beat;
    bit                    typed;
    lts_pkg::result_beat_t want;
  } script_row_t;

  localparam int RANDOM_TICKS = 160;
  localparam int SETTINGS_RUNS = 5;
  localparam int TAIL_CYCLES = 25;

  // Clock, reset and DUT ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  lts_pkg::tick_beat_t tick = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  lts_pkg::result_beat_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Sequencer shadow state
  logic [1:0] word_syms [lts_pkg::WORD_SLOTS];
  int word_size;
  int cur_pos;
  logic [lts_pkg::DUR_BITS-1:0] tick_cnt;
  logic [lts_pkg::DUR_BITS-1:0] dur_latched;
  logic [lts_pkg::PULSE_BITS-1:0] pulse_count;
  logic [lts_pkg::RULE_BITS-1:0] rule_reg [4];
  logic [lts_pkg::PULSE_BITS-1:0] pulse_len;

  lts_pkg::result_beat_t awaited_results [$];
  int error_count = 0;
  bit feed_calm = 1'b0;
  bit drain_calm = 1'b0;
  script_row_t script [16];

  lsystem_trigger_sequencer uut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick(tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [lts_pkg::DUR_BITS-1:0] duration_for(lts_pkg::tick_beat_t b,
                                                                logic [1:0] sym);
    case (sym)
      lts_pkg::SYM_A: return b.dur_a_ticks;
      lts_pkg::SYM_B: return b.dur_b_ticks;
      lts_pkg::SYM_C: return b.dur_c_ticks;
      default: return b.dur_d_ticks;
    endcase
  endfunction

  // Advance the shadow sequencer by one tick and return what the block should emit
  function automatic lts_pkg::result_beat_t next_tick_result(lts_pkg::tick_beat_t b);
    lts_pkg::result_beat_t r;
    logic [1:0] fresh [lts_pkg::WORD_SLOTS];
    logic [lts_pkg::RULE_BITS-1:0] rl;
    logic begun;
    int n, i, k, len;
    begun = 1'b0;
    if (b.restart) begin
      word_size = 0;
      cur_pos = 0;
      tick_cnt = '0;
    end
    // empty word: seed with a
    if (word_size == 0) begin
      cur_pos = 0;
      word_syms[0] = lts_pkg::SYM_A;
      word_size = 1;
      dur_latched = duration_for(b, lts_pkg::SYM_A);
      begun = 1'b1;
    end
    if (tick_cnt != lts_pkg::DUR_MAX) tick_cnt = tick_cnt + lts_pkg::DUR_BITS'(1);
    if (tick_cnt >= dur_latched) begin
      pulse_count = pulse_len;
      tick_cnt = '0;
      cur_pos++;
      if (cur_pos >= word_size) cur_pos = 0;
      // wrapped: rewrite the word, truncated at WORD_SLOTS
      if (cur_pos == 0) begin
        fresh = word_syms;
        n = 0;
        for (i = 0; i < word_size && n < lts_pkg::WORD_SLOTS; i++) begin
          rl = rule_reg[word_syms[i]];
          len = (rl[3:0] > lts_pkg::RULE_SLOTS) ? lts_pkg::RULE_SLOTS : rl[3:0];
          for (k = 0; k < len && n < lts_pkg::WORD_SLOTS; k++) begin
            fresh[n] = rl[4 + 2*k +: 2];
            n++;
          end
        end
        word_syms = fresh;
        word_size = n;
        if (word_size == 0) begin
          word_syms[0] = lts_pkg::SYM_A;
          word_size = 1;
        end
      end
      dur_latched = duration_for(b, word_syms[cur_pos]);
      begun = 1'b1;
    end
    r.gate = (pulse_count != 0);
    if (r.gate) pulse_count = pulse_count - lts_pkg::PULSE_BITS'(1);
    r.symbol_now = word_syms[cur_pos];
    r.position_now = lts_pkg::POS_W'(cur_pos);
    r.word_length = lts_pkg::LEN_W'(word_size);
    r.symbol_start = begun;
    return r;
  endfunction

  // Mostly short durations so words advance; now and then a full-range value
  function automatic logic [lts_pkg::DUR_BITS-1:0] draw_duration();
    if ($urandom_range(0, 19) == 0) return lts_pkg::DUR_BITS'($urandom);
    return lts_pkg::DUR_BITS'($urandom_range(0, 4));
  endfunction

  function automatic lts_pkg::tick_beat_t random_tick();
    lts_pkg::tick_beat_t t;
    t.restart = ($urandom_range(0, 19) == 0);
    t.dur_a_ticks = draw_duration();
    t.dur_b_ticks = draw_duration();
    t.dur_c_ticks = draw_duration();
    t.dur_d_ticks = draw_duration();
    return t;
  endfunction

  // One beat on the tick channel; called at a rising edge
  task automatic send_tick(input lts_pkg::tick_beat_t b, input bit typed,
                           input lts_pkg::result_beat_t want);
    lts_pkg::result_beat_t predicted;
    int gap;
    if ($urandom_range(0, 31) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick <= b;
    tick_valid <= 1'b1;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    predicted = next_tick_result(b);
    awaited_results = {awaited_results, (typed ? want : predicted)};
  endtask

  // Hold off the sender until every awaited result is back
  task automatic drain();
    tick_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == lts_pkg::REG_PULSE) pulse_len = data[lts_pkg::PULSE_BITS-1:0];
    else rule_reg[idx[1:0]] = data[lts_pkg::RULE_BITS-1:0];
  endtask

  task automatic load_settings(input logic [lts_pkg::RULE_BITS-1:0] ra,
                               input logic [lts_pkg::RULE_BITS-1:0] rb,
                               input logic [lts_pkg::RULE_BITS-1:0] rc,
                               input logic [lts_pkg::RULE_BITS-1:0] rd,
                               input logic [lts_pkg::PULSE_BITS-1:0] pl);
    apb_write(lts_pkg::REG_RULE_A, 32'(ra));
    apb_write(lts_pkg::REG_RULE_B, 32'(rb));
    apb_write(lts_pkg::REG_RULE_C, 32'(rc));
    apb_write(lts_pkg::REG_RULE_D, 32'(rd));
    apb_write(lts_pkg::REG_PULSE, 32'(pl));
  endtask

  // Result side: random stall before each beat, with calm stretches
  initial begin
    int hold;
    wait (!rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) drain_calm = !drain_calm;
      hold = drain_calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
    end
  end

  // Compare each result beat with the oldest awaited one
  always @(posedge clk) begin
    lts_pkg::result_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: %h", result);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result.gate !== want.gate) begin
          $error("gate: expected %0d, got %0d", want.gate, result.gate);
          error_count++;
        end
        if (result.symbol_now !== want.symbol_now) begin
          $error("symbol_now: expected %0d, got %0d", want.symbol_now, result.symbol_now);
          error_count++;
        end
        if (result.position_now !== want.position_now) begin
          $error("position_now: expected %0d, got %0d", want.position_now, result.position_now);
          error_count++;
        end
        if (result.word_length !== want.word_length) begin
          $error("word_length: expected %0d, got %0d", want.word_length, result.word_length);
          error_count++;
        end
        if (result.symbol_start !== want.symbol_start) begin
          $error("symbol_start: expected %0d, got %0d", want.symbol_start, result.symbol_start);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int run, j;
    // directed: the first rows are read straight off the reset state (empty rules, pulse 48)
    script = '{
      '{'{1'b0, 24'd3, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{1'b0, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b1}},
      '{'{1'b0, lts_pkg::DUR_MAX, lts_pkg::DUR_MAX, lts_pkg::DUR_MAX, lts_pkg::DUR_MAX}, 1'b1,
        '{1'b0, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b0}},
      '{'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{1'b1, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b1}},
      '{'{1'b0, lts_pkg::DUR_MAX, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{1'b1, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b1}},
      '{'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{1'b1, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b0}},
      '{'{1'b1, 24'd1, lts_pkg::DUR_MAX, lts_pkg::DUR_MAX, lts_pkg::DUR_MAX}, 1'b1,
        '{1'b1, lts_pkg::SYM_A, 4'd0, 5'd1, 1'b1}},
      '{'{1'b0, 24'd2, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b1, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b1, 24'd5, 24'd1, 24'd1, 24'd1}, 1'b0, '0},
      '{'{1'b0, 24'h800000, 24'h555555, 24'hAAAAAA, 24'd1}, 1'b0, '0},
      '{'{1'b1, 24'd1, 24'h2AAAAA, 24'h555555, 24'h7FFFFF}, 1'b0, '0},
      '{'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b0, 24'd1, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{'{1'b0, 24'd3, 24'd3, 24'd3, 24'd3}, 1'b0, '0}
    };
    for (j = 0; j < lts_pkg::WORD_SLOTS; j++) word_syms[j] = lts_pkg::SYM_A;
    word_size = 0;
    cur_pos = 0;
    tick_cnt = '0;
    dur_latched = '0;
    pulse_count = '0;
    for (j = 0; j < 4; j++) rule_reg[j] = '0;
    pulse_len = lts_pkg::PULSE_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (j = 0; j < 16; j++) send_tick(script[j].beat, script[j].typed, script[j].want);
    drain();

    // random ticks under several rule sets, written while the block is idle
    for (run = 0; run < SETTINGS_RUNS; run++) begin
      case (run)
        // a->ab, b->a, c->cda, d->db
        0: load_settings({16'h0004, 4'd2}, {16'h0000, 4'd1}, {16'h000E, 4'd3},
                         {16'h0007, 4'd2}, 16'd3);
        // length fields above the slot count, no pulse
        1: load_settings({16'($urandom), 4'hF}, {16'($urandom), 4'hF},
                         {16'($urandom), 4'hF}, {16'($urandom), 4'hF}, 16'd0);
        // all ones
        2: load_settings('1, '1, '1, '1, 16'hFFFF);
        // a->b, b->nothing: the rewrite comes out empty
        3: load_settings({16'h0001, 4'd1}, {16'h0000, 4'd0}, lts_pkg::RULE_BITS'($urandom),
                         lts_pkg::RULE_BITS'($urandom), 16'd1);
        default: load_settings(lts_pkg::RULE_BITS'($urandom), lts_pkg::RULE_BITS'($urandom),
                               lts_pkg::RULE_BITS'($urandom), lts_pkg::RULE_BITS'($urandom),
                               lts_pkg::PULSE_BITS'($urandom));
      endcase
      for (j = 0; j < RANDOM_TICKS; j++) send_tick(random_tick(), 1'b0, '0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  // Run limit
  initial begin
    #1000000;
    $display("testbench failed");
    $finish;
  end

endmodule
